@@ hdl/dbpp_pkg.sv @@
`timescale 1ns / 1ps

package dbpp_pkg;

	localparam int SCREEN_ROWS_DEF    = 256;
	localparam int SCREEN_COLUMNS_DEF = 256;

	// row * columns + column for 8-bit coordinates and up to 256 columns
	localparam int CALC_W = 17;
	// coordinate compared against a screen size of up to 256
	localparam int COORD_CMP_W = 9;

	localparam logic [1:0] OP_PORT_WRITE   = 2'd0;
	localparam logic [1:0] OP_PORT_READ    = 2'd1;
	localparam logic [1:0] OP_DISPLAY_READ = 2'd2;

	localparam logic [7:0] MODE_SET_PIXEL  = 8'd0;
	localparam logic [7:0] MODE_SWAP       = 8'd1;
	localparam logic [7:0] MODE_CLEAR      = 8'd2;
	localparam logic [7:0] MODE_READ_PIXEL = 8'd3;

	localparam logic [7:0] CNT_MODE   = 8'd0;
	localparam logic [7:0] CNT_ROW    = 8'd1;
	localparam logic [7:0] CNT_COLUMN = 8'd2;
	localparam logic [7:0] CNT_COLOR  = 8'd3;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PIX_WR,
		ST_BACK_RD,
		ST_BACK_DONE,
		ST_FRONT_RD,
		ST_FRONT_DONE,
		ST_COPY,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic pix_wr;
		logic back_rd;
		logic front_rd;
		logic copy;
		logic clear;
	} dec_t;

	typedef struct packed {
		dec_t dec;
		logic sweep_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic take;
		logic load_zero;
		logic pix_wr;
		logic back_rd;
		logic front_rd;
		logic load_back;
		logic load_front;
		logic copy_rd;
		logic clr_wr;
		logic init_wr;
		logic sweep_inc;
	} cmd_t;

endpackage

@@ hdl/dbpp_in_if.sv @@
`timescale 1ns / 1ps

interface dbpp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] write_byte;
	logic [7:0] display_row;
	logic [7:0] display_column;

	modport source (
		output valid, opcode, write_byte, display_row, display_column,
		input  ready
	);
	modport sink (
		input  valid, opcode, write_byte, display_row, display_column,
		output ready
	);
endinterface

@@ hdl/dbpp_out_if.sv @@
`timescale 1ns / 1ps

interface dbpp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (
		output valid, read_data,
		input  ready
	);
	modport sink (
		input  valid, read_data,
		output ready
	);
endinterface

@@ hdl/dbpp_ctrl.sv @@
`timescale 1ns / 1ps

module dbpp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dbpp_pkg::status_t sts,
	output dbpp_pkg::cmd_t    cmd
);

	dbpp_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbpp_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			dbpp_pkg::ST_INIT: begin
				// both buffers zeroed one entry a cycle
				cmd.init_wr   = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = dbpp_pkg::ST_IDLE;
				end
			end
			dbpp_pkg::ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.take = 1'b1;
					if (sts.dec.back_rd) begin
						state_nxt = dbpp_pkg::ST_BACK_RD;
					end else if (sts.dec.front_rd) begin
						state_nxt = dbpp_pkg::ST_FRONT_RD;
					end else begin
						cmd.load_zero = 1'b1;
						if (sts.dec.pix_wr) begin
							state_nxt = dbpp_pkg::ST_PIX_WR;
						end else if (sts.dec.copy) begin
							state_nxt = dbpp_pkg::ST_COPY;
						end else if (sts.dec.clear) begin
							state_nxt = dbpp_pkg::ST_CLEAR;
						end
					end
				end
			end
			dbpp_pkg::ST_PIX_WR: begin
				cmd.pix_wr = 1'b1;
				state_nxt  = dbpp_pkg::ST_IDLE;
			end
			dbpp_pkg::ST_BACK_RD: begin
				cmd.back_rd = 1'b1;
				state_nxt   = dbpp_pkg::ST_BACK_DONE;
			end
			dbpp_pkg::ST_BACK_DONE: begin
				cmd.load_back = 1'b1;
				state_nxt     = dbpp_pkg::ST_IDLE;
			end
			dbpp_pkg::ST_FRONT_RD: begin
				cmd.front_rd = 1'b1;
				state_nxt    = dbpp_pkg::ST_FRONT_DONE;
			end
			dbpp_pkg::ST_FRONT_DONE: begin
				cmd.load_front = 1'b1;
				state_nxt      = dbpp_pkg::ST_IDLE;
			end
			dbpp_pkg::ST_COPY: begin
				cmd.copy_rd   = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = dbpp_pkg::ST_IDLE;
				end
			end
			dbpp_pkg::ST_CLEAR: begin
				cmd.clr_wr    = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = dbpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dbpp_pkg::ST_INIT;
			end
		endcase
	end

endmodule

@@ hdl/dbpp_datapath.sv @@
`timescale 1ns / 1ps

module dbpp_datapath #(
	parameter int SCREEN_ROWS    = dbpp_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLUMNS = dbpp_pkg::SCREEN_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         opcode,
	input  logic [7:0]         write_byte,
	input  logic [7:0]         display_row,
	input  logic [7:0]         display_column,
	input  logic               out_ready,
	input  dbpp_pkg::cmd_t     cmd,
	output dbpp_pkg::status_t  sts,
	output logic               out_valid,
	output logic [7:0]         read_data
);

	localparam int DEPTH = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [7:0] back_mem  [DEPTH];
	logic [7:0] front_mem [DEPTH];

	logic [7:0]    cnt_q, mode_q, row_q, col_q, color_q;
	logic [AW-1:0] addr_q, sw_q, addr_s1;
	logic          onscr_q, copy_s1;
	logic [7:0]    back_rd_q, front_rd_q;
	logic          out_valid_q;
	logic [7:0]    read_data_q;

	logic [7:0] cnt_inc, cnt_nxt, mode_nxt, row_nxt, col_nxt, color_nxt;
	logic [7:0] sel_row, sel_col;
	logic [dbpp_pkg::CALC_W-1:0] calc;
	logic       onscr;
	dbpp_pkg::dec_t dec;

	logic          back_we, front_we;
	logic [AW-1:0] back_wa, back_ra, front_wa;
	logic [7:0]    back_wd, front_wd;

	// decode of the offered item against the port state
	always_comb begin
		cnt_inc   = cnt_q + 8'd1;
		cnt_nxt   = cnt_q;
		mode_nxt  = mode_q;
		row_nxt   = row_q;
		col_nxt   = col_q;
		color_nxt = color_q;
		dec       = '0;
		case (opcode)
			dbpp_pkg::OP_PORT_WRITE: begin
				unique case (cnt_q)
					dbpp_pkg::CNT_MODE:   mode_nxt  = write_byte;
					dbpp_pkg::CNT_ROW:    row_nxt   = write_byte;
					dbpp_pkg::CNT_COLUMN: col_nxt   = write_byte;
					dbpp_pkg::CNT_COLOR:  color_nxt = write_byte;
					default: ;
				endcase
				cnt_nxt = cnt_inc;
				if (cnt_inc > dbpp_pkg::CNT_COLOR) begin
					cnt_nxt    = '0;
					dec.pix_wr = (mode_nxt == dbpp_pkg::MODE_SET_PIXEL);
				end else if (mode_nxt == dbpp_pkg::MODE_SWAP) begin
					cnt_nxt  = '0;
					dec.copy = 1'b1;
				end else if (mode_nxt == dbpp_pkg::MODE_CLEAR) begin
					cnt_nxt   = '0;
					dec.clear = 1'b1;
				end
			end
			dbpp_pkg::OP_PORT_READ: begin
				cnt_nxt = cnt_inc;
				if (cnt_inc > dbpp_pkg::CNT_COLUMN &&
				    mode_q == dbpp_pkg::MODE_READ_PIXEL) begin
					cnt_nxt     = '0;
					dec.back_rd = 1'b1;
				end
			end
			dbpp_pkg::OP_DISPLAY_READ: begin
				dec.front_rd = 1'b1;
			end
			default: ;
		endcase
	end

	// pixel address: held coordinates, or the display coordinates of a display read
	always_comb begin
		sel_row = (opcode == dbpp_pkg::OP_DISPLAY_READ) ? display_row    : row_q;
		sel_col = (opcode == dbpp_pkg::OP_DISPLAY_READ) ? display_column : col_q;
		calc    = dbpp_pkg::CALC_W'(sel_row) * dbpp_pkg::CALC_W'(SCREEN_COLUMNS)
		        + dbpp_pkg::CALC_W'(sel_col);
		onscr   = (dbpp_pkg::COORD_CMP_W'(sel_row) < dbpp_pkg::COORD_CMP_W'(SCREEN_ROWS)) &&
		          (dbpp_pkg::COORD_CMP_W'(sel_col) < dbpp_pkg::COORD_CMP_W'(SCREEN_COLUMNS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			mode_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			color_q     <= '0;
			sw_q        <= '0;
			copy_s1     <= 1'b0;
			onscr_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				cnt_q   <= cnt_nxt;
				mode_q  <= mode_nxt;
				row_q   <= row_nxt;
				col_q   <= col_nxt;
				color_q <= color_nxt;
				onscr_q <= onscr;
			end
			if (cmd.sweep_inc) begin
				sw_q <= (sw_q == LAST_ADDR) ? '0 : sw_q + 1'b1;
			end
			copy_s1 <= cmd.copy_rd;
			if (cmd.load_zero || cmd.load_back || cmd.load_front) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			addr_q <= calc[AW-1:0];
		end
		addr_s1 <= sw_q;
		if (cmd.load_zero) begin
			read_data_q <= '0;
		end else if (cmd.load_back) begin
			read_data_q <= onscr_q ? back_rd_q : '0;
		end else if (cmd.load_front) begin
			read_data_q <= onscr_q ? front_rd_q : '0;
		end
	end

	// back buffer: one write port, one registered read port
	always_comb begin
		back_we = cmd.init_wr || cmd.clr_wr || (cmd.pix_wr && onscr_q);
		back_wa = cmd.pix_wr ? addr_q : sw_q;
		back_wd = cmd.pix_wr ? color_q : '0;
		back_ra = cmd.copy_rd ? sw_q : addr_q;
	end

	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_wa] <= back_wd;
		end
		if (cmd.back_rd || cmd.copy_rd) begin
			back_rd_q <= back_mem[back_ra];
		end
	end

	// front buffer: copy write follows the back read in the next cycle
	always_comb begin
		front_we = cmd.init_wr || copy_s1;
		front_wa = copy_s1 ? addr_s1 : sw_q;
		front_wd = copy_s1 ? back_rd_q : '0;
	end

	always_ff @(posedge clk) begin
		if (front_we) begin
			front_mem[front_wa] <= front_wd;
		end
		if (cmd.front_rd) begin
			front_rd_q <= front_mem[addr_q];
		end
	end

	assign sts.dec        = dec;
	assign sts.sweep_last = (sw_q == LAST_ADDR);
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;

endmodule

@@ hdl/double_buffered_pixel_port_unit.sv @@
`timescale 1ns / 1ps

// double-buffered pixel port: byte port in front of a back and a front pixel buffer
// req carries one item per port access: opcode (port write, port read, display
// read), the written byte and the display coordinates; rsp returns one byte
// per item, in order
// port writes step through mode, row, column and colour; the set-pixel write
// lands in the back buffer, a swap copies back to front and a clear zeroes back
// a write result is registered on acceptance; a pixel read (port read in
// read-pixel mode or display read) reads the buffer's registered read port in
// its read state and then loads the result in its done state; one item is in
// flight at a time, so no new item is taken before the current one is through,
// a set-pixel write passing its write state and a pixel read both its states
// swap and clear walk all ROWS * COLUMNS buffer entries (65536 at the default size)
// one entry a cycle, and no item is taken during the walk
// after reset both buffers are zeroed by the same walk over all entries,
// before req.ready rises
// a stalled rsp holds its result; req stays ready only while the output
// register is empty or being emptied
module double_buffered_pixel_port_unit #(
	parameter int SCREEN_ROWS    = dbpp_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLUMNS = dbpp_pkg::SCREEN_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dbpp_in_if.sink     req,
	dbpp_out_if.source  rsp
);

	dbpp_pkg::cmd_t    cmd;
	dbpp_pkg::status_t sts;

	dbpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dbpp_datapath #(
		.SCREEN_ROWS    (SCREEN_ROWS),
		.SCREEN_COLUMNS (SCREEN_COLUMNS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (req.opcode),
		.write_byte     (req.write_byte),
		.display_row    (req.display_row),
		.display_column (req.display_column),
		.out_ready      (rsp.ready),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (rsp.valid),
		.read_data      (rsp.read_data)
	);

endmodule
